[rtl/pptc_pkg.sv]
// Package for the push/pop trace classifier: sizes, codes and shared types.
`timescale 1ns / 1ps
package pptc_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);
  localparam int unsigned DataW      = 32;

  // Discipline that a chain models.
  localparam logic [1:0] KIND_STACK = 2'd0;
  localparam logic [1:0] KIND_QUEUE = 2'd1;
  localparam logic [1:0] KIND_HEAP  = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
  localparam logic [2:0] VERDICT_STACK      = 3'd1;
  localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
  localparam logic [2:0] VERDICT_PRIO       = 3'd3;
  localparam logic [2:0] VERDICT_NOT_SURE   = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_NEW,
    CELL_PREV,
    CELL_NEXT
  } cell_op_e;

  typedef struct packed {
    logic fit;  // model still consistent after this word
    logic ovf;  // this word's push met a full chain
  } chain_stat_t;

endpackage

[rtl/pptc_cell.sv]
// One storage cell of a chain: holds its value, loads a new one or takes one from a neighbor.
`timescale 1ns / 1ps
module pptc_cell (
  input  logic                                clk_i,
  input  pptc_pkg::cell_op_e                  op_i,
  input  logic signed [pptc_pkg::DataW-1:0]   prev_i,
  input  logic signed [pptc_pkg::DataW-1:0]   next_i,
  input  logic signed [pptc_pkg::DataW-1:0]   new_i,
  output logic signed [pptc_pkg::DataW-1:0]   val_o
);

  logic signed [pptc_pkg::DataW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    case (op_i)
      pptc_pkg::CELL_NEW:  val_q <= new_i;
      pptc_pkg::CELL_PREV: val_q <= prev_i;
      pptc_pkg::CELL_NEXT: val_q <= next_i;
      default:             val_q <= val_q;
    endcase
  end

  assign val_o = val_q;

endmodule

[rtl/pptc_chain.sv]
// A row of cells modeling a stack, a queue or a sorted priority queue.
`timescale 1ns / 1ps
module pptc_chain (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [1:0]                         kind_i,
  input  logic                               valid_i,
  input  logic                               pop_i,
  input  logic signed [pptc_pkg::DataW-1:0]  value_i,
  input  logic                               clear_i,
  output pptc_pkg::chain_stat_t              stat_o
);

  localparam int unsigned Depth = pptc_pkg::StoreDepth;
  localparam int unsigned IdxW  = pptc_pkg::IdxW;
  localparam int unsigned CntW  = pptc_pkg::CntW;

  logic [CntW-1:0] count_q, count_d;
  logic            fit_q, fit_d;
  logic            ovf, do_push, do_pop;

  logic signed [pptc_pkg::DataW-1:0] val [Depth];
  logic                              ins [Depth];

  always_comb begin
    fit_d   = fit_q;
    count_d = count_q;
    ovf     = 1'b0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    if (valid_i && fit_q) begin
      if (pop_i == pptc_pkg::OP_PUSH) begin
        if (count_q == CntW'(Depth)) begin
          ovf = 1'b1;
        end else begin
          do_push = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else if (count_q == '0 || val[0] != value_i) begin
        fit_d = 1'b0;
      end else begin
        do_pop  = 1'b1;
        count_d = count_q - 1'b1;
      end
    end
  end

  assign stat_o.fit = fit_d;
  assign stat_o.ovf = ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fit_q   <= 1'b1;
    end else if (clear_i) begin
      count_q <= '0;
      fit_q   <= 1'b1;
    end else begin
      count_q <= count_d;
      fit_q   <= fit_d;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [pptc_pkg::DataW-1:0] prev_val, next_val;
    logic                              prev_ins;
    pptc_pkg::cell_op_e                op;

    // Sorted descending: insert point is the first cell not >= value.
    assign ins[i] = !((CntW'(i) < count_q) && (val[i] >= value_i));

    if (i == 0) begin : g_first
      assign prev_val = value_i;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_val = val[i-1];
      assign prev_ins = ins[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_val = val[i];
    end else begin : g_inner
      assign next_val = val[i+1];
    end

    always_comb begin
      op = pptc_pkg::CELL_HOLD;
      if (do_pop) begin
        op = pptc_pkg::CELL_NEXT;
      end else if (do_push) begin
        case (kind_i)
          pptc_pkg::KIND_STACK: begin
            op = (i == 0) ? pptc_pkg::CELL_NEW : pptc_pkg::CELL_PREV;
          end
          pptc_pkg::KIND_QUEUE: begin
            op = (count_q[IdxW-1:0] == IdxW'(i)) ? pptc_pkg::CELL_NEW
                                                  : pptc_pkg::CELL_HOLD;
          end
          pptc_pkg::KIND_HEAP: begin
            if (!ins[i])       op = pptc_pkg::CELL_HOLD;
            else if (prev_ins) op = pptc_pkg::CELL_PREV;
            else               op = pptc_pkg::CELL_NEW;
          end
          default: op = pptc_pkg::CELL_HOLD;
        endcase
      end
    end

    pptc_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .prev_i (prev_val),
      .next_i (next_val),
      .new_i  (value_i),
      .val_o  (val[i])
    );
  end

endmodule

[rtl/push_pop_trace_classifier.sv]
// Top level of the push/pop trace classifier.
`timescale 1ns / 1ps
// Replays a run of push/pop words against a stack, a FIFO queue and a
// max-priority queue at once, each a chain of 1024 cells that shift as a
// unit, and reports on the word marked last which of them fits (or none,
// or not sure) plus whether any push met a full chain. Each chain applies
// a push or pop in a single shift of its cells (the priority chain stays
// sorted, so insertion is a parallel compare per cell and pop is a shift
// toward the head). A word is taken every cycle unless a verdict is
// waiting on a stalled output. After the verdict word all models start
// over empty; no clearing pass is needed.
module push_pop_trace_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [pptc_pkg::DataW-1:0]  value_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         verdict_o,
  output logic                               overflow_o
);

  logic        accept, clear;
  logic        out_valid_q;
  logic [2:0]  verdict_q;
  logic        overflow_q;
  logic        ovf_seen_q;
  logic [2:0]  fits;
  logic [2:0]  verdict_d;
  logic        ovf_now;

  pptc_pkg::chain_stat_t st_stack, st_queue, st_heap;

  // Output register parts the two sides; only a held verdict blocks input.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign clear      = accept && last_i;

  pptc_chain u_stack (
    .clk_i, .rst_ni,
    .kind_i  (pptc_pkg::KIND_STACK),
    .valid_i (accept),
    .pop_i   (opcode_i),
    .value_i (value_i),
    .clear_i (clear),
    .stat_o  (st_stack)
  );

  pptc_chain u_queue (
    .clk_i, .rst_ni,
    .kind_i  (pptc_pkg::KIND_QUEUE),
    .valid_i (accept),
    .pop_i   (opcode_i),
    .value_i (value_i),
    .clear_i (clear),
    .stat_o  (st_queue)
  );

  pptc_chain u_heap (
    .clk_i, .rst_ni,
    .kind_i  (pptc_pkg::KIND_HEAP),
    .valid_i (accept),
    .pop_i   (opcode_i),
    .value_i (value_i),
    .clear_i (clear),
    .stat_o  (st_heap)
  );

  // Flags after this word is applied.
  assign fits    = {st_heap.fit, st_queue.fit, st_stack.fit};
  assign ovf_now = st_stack.ovf || st_queue.ovf || st_heap.ovf;

  always_comb begin
    unique case (fits)
      3'b000:  verdict_d = pptc_pkg::VERDICT_IMPOSSIBLE;
      3'b001:  verdict_d = pptc_pkg::VERDICT_STACK;
      3'b010:  verdict_d = pptc_pkg::VERDICT_QUEUE;
      3'b100:  verdict_d = pptc_pkg::VERDICT_PRIO;
      default: verdict_d = pptc_pkg::VERDICT_NOT_SURE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear)        ovf_seen_q <= 1'b0;
      else if (accept)  ovf_seen_q <= ovf_seen_q || ovf_now;
      if (clear)             out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      verdict_q  <= verdict_d;
      overflow_q <= ovf_seen_q || ovf_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign overflow_o  = overflow_q;

endmodule

[bench/tb_push_pop_trace_classifier.sv]
// Testbench for the push/pop trace classifier: stimulus, prediction and checking.
`timescale 1ns / 1ps
module tb_push_pop_trace_classifier;

  // Predicts the verdict of each run and holds the verdicts still to arrive.
  class trace_scoreboard;
    int          stk[$];    // stack, top at the back
    int          fifo[$];   // queue, head at the front
    int          prio[$];   // max-priority queue, unordered multiset
    bit [2:0]    fit;       // bit0 stack, bit1 queue, bit2 heap
    bit          ovf;
    logic [2:0]  want_verdict[$];
    bit          want_ovf[$];
    int          mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      stk.delete();
      fifo.delete();
      prio.delete();
      fit = 3'b111;
      ovf = 1'b0;
    endfunction

    function int pending();
      return want_verdict.size();
    endfunction

    // Apply one accepted word to all three models.
    function void note_word(logic op, int v, logic last);
      int mi;
      logic [2:0] vd;
      if (fit[0]) begin
        if (op == pptc_pkg::OP_PUSH) begin
          if (stk.size() >= pptc_pkg::StoreDepth) ovf = 1'b1;
          else stk.push_back(v);
        end else if (stk.size() == 0 || stk[$] != v) fit[0] = 1'b0;
        else void'(stk.pop_back());
      end
      if (fit[1]) begin
        if (op == pptc_pkg::OP_PUSH) begin
          if (fifo.size() >= pptc_pkg::StoreDepth) ovf = 1'b1;
          else fifo.push_back(v);
        end else if (fifo.size() == 0 || fifo[0] != v) fit[1] = 1'b0;
        else void'(fifo.pop_front());
      end
      if (fit[2]) begin
        if (op == pptc_pkg::OP_PUSH) begin
          if (prio.size() >= pptc_pkg::StoreDepth) ovf = 1'b1;
          else prio.push_back(v);
        end else begin
          mi = 0;
          foreach (prio[i]) if (prio[i] > prio[mi]) mi = i;
          if (prio.size() == 0 || prio[mi] != v) fit[2] = 1'b0;
          else prio.delete(mi);
        end
      end
      if (last) begin
        case (fit)
          3'b000:  vd = pptc_pkg::VERDICT_IMPOSSIBLE;
          3'b001:  vd = pptc_pkg::VERDICT_STACK;
          3'b010:  vd = pptc_pkg::VERDICT_QUEUE;
          3'b100:  vd = pptc_pkg::VERDICT_PRIO;
          default: vd = pptc_pkg::VERDICT_NOT_SURE;
        endcase
        want_verdict.push_back(vd);
        want_ovf.push_back(ovf);
        clear();
      end
    endfunction

    function void check_result(logic [2:0] vd, logic ov);
      logic [2:0] ev;
      bit eo;
      if (want_verdict.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict word: verdict %0d overflow %0d", vd, ov);
        return;
      end
      ev = want_verdict.pop_front();
      eo = want_ovf.pop_front();
      if (vd !== ev || ov !== eo) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: expected verdict %0d overflow %0d, got %0d %0d",
                   ev, eo, vd, ov);
      end
    endfunction
  endclass

  typedef enum int {GEN_STACK, GEN_QUEUE, GEN_HEAP, GEN_NOISE} gen_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        opcode_i = pptc_pkg::OP_PUSH;
  logic signed [pptc_pkg::DataW-1:0] value_i = '0;
  logic        last_i = 1'b0;
  logic        out_stall_i = 1'b0;
  wire         in_stall_o;
  wire         out_valid_o;
  wire  [2:0]  verdict_o;
  wire         overflow_o;

  trace_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 400000;

  push_pop_trace_classifier dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .value_i, .last_i,
    .out_valid_o, .out_stall_i, .verdict_o, .overflow_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Cycle count and timeout guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_push_pop_trace_classifier: FAIL");
      $finish;
    end
  end

  // Result side: check accepted verdicts, then pick next cycle's stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(verdict_o, overflow_o);
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Drive one word; the model is updated at the edge that takes it.
  // Idle cycles are drawn one at a time, so the sender idles in about
  // send_idle_pct cycles of a hundred.
  task automatic send_word(logic op, int v, logic last);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= v;
    last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, v, last);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // One run shaped after a discipline, so pops mostly return what that
  // discipline would; noise runs and a rare corrupted pop break the fit.
  task automatic run_trace(gen_kind_e kind, int len, bit narrow);
    int held[$];
    int v, mi;
    logic op;
    for (int i = 0; i < len; i++) begin
      op = (held.size() == 0 || $urandom_range(0, 1)) ? pptc_pkg::OP_PUSH : pptc_pkg::OP_POP;
      if (op == pptc_pkg::OP_PUSH || kind == GEN_NOISE) begin
        v = narrow ? $urandom_range(0, 3) - 2 : $urandom;
        if (op == pptc_pkg::OP_PUSH) held.push_back(v);
      end else begin
        case (kind)
          GEN_STACK: v = held.pop_back();
          GEN_QUEUE: v = held.pop_front();
          default: begin
            mi = 0;
            foreach (held[j]) if (held[j] > held[mi]) mi = j;
            v = held[mi];
            held.delete(mi);
          end
        endcase
        if ($urandom_range(0, 19) == 0) v = v ^ (1 << $urandom_range(0, 31));
      end
      send_word(op, v, i == len - 1);
    end
  endtask

  initial begin
    int mark;
    bit drained;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a stack run with the value extremes; the heap fits it too.
    send_word(pptc_pkg::OP_PUSH, 32'sh8000_0000, 1'b0);
    send_word(pptc_pkg::OP_PUSH, 32'sh7fff_ffff, 1'b0);
    send_word(pptc_pkg::OP_POP,  32'sh7fff_ffff, 1'b0);
    send_word(pptc_pkg::OP_POP,  32'sh8000_0000, 1'b1);
    // Queue only: pop returns oldest, which is smaller.
    send_word(pptc_pkg::OP_PUSH, -5, 1'b0);
    send_word(pptc_pkg::OP_PUSH, 9, 1'b0);
    send_word(pptc_pkg::OP_POP,  -5, 1'b1);
    // Heap only: largest of three, neither first nor last pushed.
    send_word(pptc_pkg::OP_PUSH, 1, 1'b0);
    send_word(pptc_pkg::OP_PUSH, 7, 1'b0);
    send_word(pptc_pkg::OP_PUSH, 2, 1'b0);
    send_word(pptc_pkg::OP_POP,  7, 1'b1);
    // Pop on empty: impossible.
    send_word(pptc_pkg::OP_POP, 0, 1'b1);
    // Single push: everything still fits.
    send_word(pptc_pkg::OP_PUSH, -1, 1'b1);
    // Wrong value on a nonempty pop.
    send_word(pptc_pkg::OP_PUSH, 3, 1'b0);
    send_word(pptc_pkg::OP_POP,  4, 1'b1);

    // Full store: one push too many, queue survives, overflow reported.
    for (int i = 0; i <= int'(pptc_pkg::StoreDepth); i++)
      send_word(pptc_pkg::OP_PUSH, i, 1'b0);
    send_word(pptc_pkg::OP_POP, 0, 1'b1);
    // Frozen models ignore later words.
    send_word(pptc_pkg::OP_POP, 1, 1'b0);
    send_word(pptc_pkg::OP_PUSH, 5, 1'b0);
    send_word(pptc_pkg::OP_POP, 5, 1'b1);
    drain();

    // Random runs in three idling phases.
    mark = words_sent;
    drained = 1'b0;
    while (words_sent - mark < 180) begin
      if (words_sent - mark < 60) begin
        send_idle_pct = 26; recv_stall_pct = 50;
      end else if (words_sent - mark < 120) begin
        send_idle_pct = 50; recv_stall_pct = 26;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      if (!drained && words_sent - mark >= 90) begin
        drain();
        drained = 1'b1;
      end
      run_trace(gen_kind_e'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14),
                $urandom_range(0, 2) == 0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_push_pop_trace_classifier: PASS");
    end else begin
      $display("tb_push_pop_trace_classifier: FAIL");
    end
    $finish;
  end

endmodule
